// ===== rtl/ddalr_pkg.sv =====
package ddalr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  // accumulator: sign-free position, one guard bit above the integer part
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  // increment: magnitude up to 1.0 plus sign
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int INC_BITS   = FRAC_BITS + 2;
  localparam int LEFT_BITS  = COORD_BITS + 1;

  localparam int DIV_ITERS    = FRAC_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(DIV_ITERS);

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic {
    BK_RUN = 1'b0,
    BK_DIV = 1'b1
  } back_state_e;

  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_item_t;

  typedef struct packed {
    op_e                   op;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } q_item_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] num_x;
    logic [COORD_BITS-1:0] num_y;
    logic [COORD_BITS-1:0] den;
    logic                  neg_x;
    logic                  neg_y;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [INC_BITS-1:0] incr_x;
    logic [INC_BITS-1:0] incr_y;
  } div_rsp_t;

endpackage

// ===== rtl/ddalr_front.sv =====
module ddalr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ddalr_pkg::in_item_t in_item_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output ddalr_pkg::q_item_t q_item_o
);

  ddalr_pkg::q_item_t                  mem_q [ddalr_pkg::Q_DEPTH];
  logic [ddalr_pkg::Q_PTR_BITS-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ddalr_pkg::Q_PTR_BITS-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ddalr_pkg::Q_CNT_BITS-1:0]    count_q, count_d;
  logic                                push, pop;
  ddalr_pkg::q_item_t                  entry;

  assign in_stall_o = (count_q == ddalr_pkg::Q_CNT_BITS'(ddalr_pkg::Q_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  // classify: decode the command, keep coordinates for loads
  always_comb begin
    entry.op      = in_item_i.cmd ? ddalr_pkg::OP_ADVANCE : ddalr_pkg::OP_LOAD;
    entry.start_x = in_item_i.start_x;
    entry.start_y = in_item_i.start_y;
    entry.end_x   = in_item_i.end_x;
    entry.end_y   = in_item_i.end_y;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ddalr_pkg::Q_CNT_BITS'(ddalr_pkg::Q_DEPTH))
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

// ===== rtl/ddalr_div.sv =====
module ddalr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddalr_pkg::div_req_t req_i,
  output ddalr_pkg::div_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [ddalr_pkg::DIV_CNT_BITS-1:0]  cnt_q;
  logic [ddalr_pkg::COORD_BITS:0]      rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [ddalr_pkg::QUO_BITS-1:0]      quo_x_q, quo_y_q;
  logic [ddalr_pkg::COORD_BITS-1:0]    den_q;
  logic                                neg_x_q, neg_y_q;
  logic [ddalr_pkg::COORD_BITS:0]      diff_x, diff_y;
  logic                                bit_x, bit_y;
  logic [ddalr_pkg::INC_BITS-1:0]      mag_x, mag_y;

  // one quotient bit per cycle, integer bit first (numerator <= denominator)
  always_comb begin
    bit_x   = (rem_x_q >= {1'b0, den_q});
    bit_y   = (rem_y_q >= {1'b0, den_q});
    diff_x  = rem_x_q - {1'b0, den_q};
    diff_y  = rem_y_q - {1'b0, den_q};
    rem_x_d = bit_x ? {diff_x[ddalr_pkg::COORD_BITS-1:0], 1'b0}
                    : {rem_x_q[ddalr_pkg::COORD_BITS-1:0], 1'b0};
    rem_y_d = bit_y ? {diff_y[ddalr_pkg::COORD_BITS-1:0], 1'b0}
                    : {rem_y_q[ddalr_pkg::COORD_BITS-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      rem_x_q <= '0;
      rem_y_q <= '0;
      quo_x_q <= '0;
      quo_y_q <= '0;
      den_q   <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        cnt_q   <= ddalr_pkg::DIV_CNT_BITS'(ddalr_pkg::DIV_ITERS - 1);
        rem_x_q <= {1'b0, req_i.num_x};
        rem_y_q <= {1'b0, req_i.num_y};
        quo_x_q <= '0;
        quo_y_q <= '0;
        den_q   <= req_i.den;
        neg_x_q <= req_i.neg_x;
        neg_y_q <= req_i.neg_y;
      end else if (busy_q) begin
        rem_x_q <= rem_x_d;
        rem_y_q <= rem_y_d;
        quo_x_q <= {quo_x_q[ddalr_pkg::QUO_BITS-2:0], bit_x};
        quo_y_q <= {quo_y_q[ddalr_pkg::QUO_BITS-2:0], bit_y};
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    mag_x        = {1'b0, quo_x_q};
    mag_y        = {1'b0, quo_y_q};
    rsp_o.done   = done_q;
    rsp_o.incr_x = neg_x_q ? -mag_x : mag_x;
    rsp_o.incr_y = neg_y_q ? -mag_y : mag_y;
  end

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/ddalr_back.sv =====
module ddalr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  ddalr_pkg::q_item_t  q_item_i,
  output ddalr_pkg::div_req_t div_req_o,
  input  ddalr_pkg::div_rsp_t div_rsp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ddalr_pkg::out_item_t out_item_o
);

  ddalr_pkg::back_state_e               state_q, state_d;
  logic [ddalr_pkg::ACC_BITS-1:0]       accum_x_q, accum_y_q;
  logic [ddalr_pkg::INC_BITS-1:0]       incr_x_q, incr_y_q;
  logic [ddalr_pkg::LEFT_BITS-1:0]      pixels_left_q;
  logic                                 out_valid_q;
  ddalr_pkg::out_item_t                 out_item_q;

  logic [ddalr_pkg::COORD_BITS:0]       dx, dy;
  logic [ddalr_pkg::COORD_BITS-1:0]     abs_x, abs_y, steps;
  logic                                 out_free;
  logic                                 load_seg, emit;

  always_comb begin
    dx    = {1'b0, q_item_i.end_x} - {1'b0, q_item_i.start_x};
    dy    = {1'b0, q_item_i.end_y} - {1'b0, q_item_i.start_y};
    abs_x = dx[ddalr_pkg::COORD_BITS] ? ddalr_pkg::COORD_BITS'(-dx)
                                      : dx[ddalr_pkg::COORD_BITS-1:0];
    abs_y = dy[ddalr_pkg::COORD_BITS] ? ddalr_pkg::COORD_BITS'(-dy)
                                      : dy[ddalr_pkg::COORD_BITS-1:0];
    steps = (abs_x > abs_y) ? abs_x : abs_y;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddalr_pkg::BK_RUN: begin
        if (q_valid_i && q_item_i.op == ddalr_pkg::OP_LOAD && steps != '0) begin
          state_d = ddalr_pkg::BK_DIV;
        end
      end
      ddalr_pkg::BK_DIV: begin
        if (div_rsp_i.done) begin
          state_d = ddalr_pkg::BK_RUN;
        end
      end
      default: state_d = ddalr_pkg::BK_RUN;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o  = 1'b0;
    load_seg = 1'b0;
    emit     = 1'b0;
    unique case (state_q)
      ddalr_pkg::BK_RUN: begin
        if (q_valid_i) begin
          priority if (q_item_i.op == ddalr_pkg::OP_LOAD) begin
            q_pop_o  = 1'b1;
            load_seg = 1'b1;
          end else if (pixels_left_q == '0) begin
            q_pop_o = 1'b1;
          end else if (out_free) begin
            q_pop_o = 1'b1;
            emit    = 1'b1;
          end else begin
            // advance waits for the output register
            q_pop_o = 1'b0;
          end
        end
      end
      ddalr_pkg::BK_DIV: begin
        q_pop_o = 1'b0;
      end
      default: q_pop_o = 1'b0;
    endcase
    div_req_o.start = load_seg && (steps != '0);
    div_req_o.num_x = abs_x;
    div_req_o.num_y = abs_y;
    div_req_o.den   = steps;
    div_req_o.neg_x = dx[ddalr_pkg::COORD_BITS];
    div_req_o.neg_y = dy[ddalr_pkg::COORD_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ddalr_pkg::BK_RUN;
      accum_x_q     <= '0;
      accum_y_q     <= '0;
      incr_x_q      <= '0;
      incr_y_q      <= '0;
      pixels_left_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_seg) begin
        accum_x_q     <= {1'b0, q_item_i.start_x, {ddalr_pkg::FRAC_BITS{1'b0}}};
        accum_y_q     <= {1'b0, q_item_i.start_y, {ddalr_pkg::FRAC_BITS{1'b0}}};
        incr_x_q      <= '0;
        incr_y_q      <= '0;
        pixels_left_q <= {1'b0, steps};
      end else if (emit) begin
        accum_x_q <= accum_x_q + {{(ddalr_pkg::ACC_BITS - ddalr_pkg::INC_BITS)
                                   {incr_x_q[ddalr_pkg::INC_BITS-1]}}, incr_x_q};
        accum_y_q <= accum_y_q + {{(ddalr_pkg::ACC_BITS - ddalr_pkg::INC_BITS)
                                   {incr_y_q[ddalr_pkg::INC_BITS-1]}}, incr_y_q};
        pixels_left_q <= pixels_left_q - 1'b1;
      end
      if (div_rsp_i.done) begin
        incr_x_q <= div_rsp_i.incr_x;
        incr_y_q <= div_rsp_i.incr_y;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q.pixel_x    <= accum_x_q[ddalr_pkg::FRAC_BITS +: ddalr_pkg::COORD_BITS];
      out_item_q.pixel_y    <= accum_y_q[ddalr_pkg::FRAC_BITS +: ddalr_pkg::COORD_BITS];
      out_item_q.last_pixel <= (pixels_left_q == ddalr_pkg::LEFT_BITS'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_no_pop_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ddalr_pkg::BK_DIV) |-> !q_pop_o)
    else $error("queue popped while dividing");

  a_emit_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (pixels_left_q != '0) && out_free)
    else $error("pixel emitted without segment or slot");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ddalr_pkg::BK_DIV))
    else $error("divider finished outside divide state");

endmodule

// ===== rtl/dda_line_rasterizer_core.sv =====
// DDA line rasterizer.
// Input channel (in_valid_i / in_stall_o / in_item_i): cmd 0 loads a segment
// from (start_x, start_y) toward (end_x, end_y); cmd 1 advances one pixel.
// Output channel (out_valid_o / out_stall_i / out_item_o): one pixel per
// advance while a segment is active, with last_pixel set on the final one.
// The end point itself is never emitted; a zero-length segment emits nothing,
// and an advance with no active segment emits nothing.
// A transfer happens on a rising edge with valid high and stall low.
// Inputs land in a 4-entry queue; the back end drains it in order.
// Advance: one pixel per cycle sustained while out_stall_i is low, the result
// registered in the output register as the back end takes the item from the queue.
// Load: the two increments come from a shared restoring divider that yields
// one quotient bit per cycle, and a load of a nonzero-length segment holds the
// back end until the divider is done; the queue keeps taking items meanwhile.
// When out_stall_i is high the pixel holds in the output register, the back end
// stops once it has another pixel to show, and the queue fills to raise
// in_stall_o. Reset clears the queue, the segment state and the output valid.
module dda_line_rasterizer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ddalr_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ddalr_pkg::out_item_t out_item_o
);

  // queue between classifier and sequencer
  logic                q_valid;
  logic                q_pop;
  ddalr_pkg::q_item_t  q_item;

  // divider handshake
  ddalr_pkg::div_req_t div_req;
  ddalr_pkg::div_rsp_t div_rsp;

  ddalr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  ddalr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ddalr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
